// ===== sv/clock_digit_wipe_renderer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the clock digit wipe renderer
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CLOCK_DIGIT_WIPE_RENDERER_UNIT_DEFINES_SVH
`define CLOCK_DIGIT_WIPE_RENDERER_UNIT_DEFINES_SVH

// Implication checked from the next cycle on, muted while reset is high.
`define CDW_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

// Implication checked at every edge, reset included.
`define CDW_ASSERT_ALWAYS(lbl, ck, ante, cons, msg) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cdw_pkg.sv =====
// ----------------------------------------------------------------------------
// cdw_pkg
// Types, constants and helper functions of the clock digit wipe renderer.
// ----------------------------------------------------------------------------
package cdw_pkg;

  localparam int NDIG              = 6;
  localparam int GLYPH_ROWS_DEF    = 10;
  localparam int GLYPH_COLS_DEF    = 6;
  localparam int FONT_ROWS         = 10;
  localparam int FONT_COLS         = 6;
  localparam int PIX_OUT_W         = 36;
  localparam int QUEUE_DEPTH       = 2;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_RENDER = 2'd1,
    MODE_LOAD   = 2'd2
  } mode_t;

  typedef logic [3:0]            digit_t;
  typedef digit_t [NDIG-1:0]     digits_t;   // index 0 is hours tens

  typedef struct packed {
    logic [3:0] frame;
    digits_t    cur;
    digits_t    prev;
  } job_t;

  // Glyph rows, bit 5 is the leftmost column.
  localparam logic [5:0] FONT [FONT_ROWS][FONT_ROWS] = '{
    '{6'h3F,6'h33,6'h33,6'h33,6'h33,6'h33,6'h33,6'h33,6'h3F,6'h3F},
    '{6'h0C,6'h0C,6'h0C,6'h0C,6'h0C,6'h0C,6'h0C,6'h0C,6'h0C,6'h0C},
    '{6'h3F,6'h3F,6'h03,6'h03,6'h3F,6'h3F,6'h30,6'h30,6'h3F,6'h3F},
    '{6'h3F,6'h3F,6'h03,6'h03,6'h3F,6'h3F,6'h03,6'h03,6'h3F,6'h3F},
    '{6'h33,6'h33,6'h33,6'h33,6'h3F,6'h3F,6'h03,6'h03,6'h03,6'h03},
    '{6'h3F,6'h3F,6'h30,6'h30,6'h3F,6'h3F,6'h03,6'h03,6'h3F,6'h3F},
    '{6'h3F,6'h3F,6'h30,6'h30,6'h3F,6'h3F,6'h33,6'h33,6'h3F,6'h3F},
    '{6'h3F,6'h3F,6'h03,6'h03,6'h03,6'h03,6'h03,6'h03,6'h03,6'h03},
    '{6'h3F,6'h3F,6'h33,6'h33,6'h3F,6'h3F,6'h33,6'h33,6'h3F,6'h3F},
    '{6'h3F,6'h3F,6'h33,6'h33,6'h3F,6'h3F,6'h03,6'h03,6'h03,6'h03}
  };

  // Glyph row of a digit; dark beyond the drawn font.
  function automatic logic [5:0] font_row(digit_t digit, logic [4:0] row);
    logic [5:0] bits;
    bits = '0;
    if (digit <= 4'd9 && row < 5'(FONT_ROWS)) begin
      bits = FONT[digit][row[3:0]];
    end
    return bits;
  endfunction

  // Saturate a value and split it into tens and ones.
  function automatic logic [7:0] to_pair(logic [5:0] v, logic [5:0] vmax);
    logic [5:0] s;
    logic [3:0] t;
    logic [5:0] o;
    s = (v > vmax) ? vmax : v;
    if (s >= 6'd50)      t = 4'd5;
    else if (s >= 6'd40) t = 4'd4;
    else if (s >= 6'd30) t = 4'd3;
    else if (s >= 6'd20) t = 4'd2;
    else if (s >= 6'd10) t = 4'd1;
    else                 t = 4'd0;
    o = s - 6'(t) * 6'd10;
    return {t, o[3:0]};
  endfunction

  // Advance the time by one second; wrap at 60, 60 and 24.
  function automatic digits_t advance(digits_t d);
    digits_t n;
    n = d;
    if (d[5] < 4'd9) begin
      n[5] = d[5] + 4'd1;
    end else begin
      n[5] = '0;
      if (d[4] < 4'd5) begin
        n[4] = d[4] + 4'd1;
      end else begin
        n[4] = '0;
        if (d[3] < 4'd9) begin
          n[3] = d[3] + 4'd1;
        end else begin
          n[3] = '0;
          if (d[2] < 4'd5) begin
            n[2] = d[2] + 4'd1;
          end else begin
            n[2] = '0;
            if (d[0] == 4'd2 && d[1] == 4'd3) begin
              n[0] = '0;
              n[1] = '0;
            end else if (d[1] == 4'd9) begin
              n[0] = d[0] + 4'd1;
              n[1] = '0;
            end else begin
              n[1] = d[1] + 4'd1;
            end
          end
        end
      end
    end
    return n;
  endfunction

endpackage

// ===== sv/cdw_ifs.sv =====
// ----------------------------------------------------------------------------
// cdw channel interfaces
// Valid/ready channels for commands, queued render jobs and pixel rows.
// ----------------------------------------------------------------------------
interface cdw_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [3:0] frame;
  logic [4:0] set_hours;
  logic [5:0] set_minutes;
  logic [5:0] set_seconds;

  modport source (output valid, mode, frame, set_hours, set_minutes, set_seconds,
                  input ready);
  modport sink   (input valid, mode, frame, set_hours, set_minutes, set_seconds,
                  output ready);
endinterface

interface cdw_job_if;
  logic          valid;
  logic          ready;
  cdw_pkg::job_t job;

  modport source (output valid, job, input ready);
  modport sink   (input valid, job, output ready);
endinterface

interface cdw_row_if;
  logic        valid;
  logic        ready;
  logic [3:0]  row_index;
  logic [35:0] row_pixels;
  logic        colon_on;
  logic        last_row;

  modport source (output valid, row_index, row_pixels, colon_on, last_row,
                  input ready);
  modport sink   (input valid, row_index, row_pixels, colon_on, last_row,
                  output ready);
endinterface

// ===== sv/cdw_front.sv =====
// ----------------------------------------------------------------------------
// cdw_front
// Accepts commands, keeps the time and queues render jobs with a snapshot.
// ----------------------------------------------------------------------------
module cdw_front (
  input  logic         clk,
  input  logic         rst,
  cdw_cmd_if.sink      cmd,
  cdw_job_if.source    jobq
);

  cdw_pkg::digits_t cur;
  cdw_pkg::digits_t prev;
  cdw_pkg::digits_t cur_next;
  cdw_pkg::digits_t prev_next;
  logic             accept;
  logic [7:0]       hh;
  logic [7:0]       mm;
  logic [7:0]       ss;

  // Stall everything while the job queue is full, to keep item order simple.
  assign cmd.ready = jobq.ready;
  assign accept    = cmd.valid && cmd.ready;

  assign jobq.valid = cmd.valid && (cmd.mode == cdw_pkg::MODE_RENDER);
  assign jobq.job   = {cmd.frame, cur, prev};

  assign hh = cdw_pkg::to_pair({1'b0, cmd.set_hours}, 6'd23);
  assign mm = cdw_pkg::to_pair(cmd.set_minutes, 6'd59);
  assign ss = cdw_pkg::to_pair(cmd.set_seconds, 6'd59);

  always_comb begin
    cur_next  = cur;
    prev_next = prev;
    if (accept) begin
      unique case (cmd.mode)
        cdw_pkg::MODE_TICK: begin
          prev_next = cur;
          cur_next  = cdw_pkg::advance(cur);
        end
        cdw_pkg::MODE_LOAD: begin
          cur_next  = {ss[3:0], ss[7:4], mm[3:0], mm[7:4], hh[3:0], hh[7:4]};
          prev_next = cur_next;
        end
        default: begin
          // render and unused codes leave the time alone
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur  <= '0;
      prev <= '0;
    end else begin
      cur  <= cur_next;
      prev <= prev_next;
    end
  end

endmodule

// ===== sv/cdw_queue.sv =====
// ----------------------------------------------------------------------------
// cdw_queue
// Short job queue that decouples command intake from row rendering.
// ----------------------------------------------------------------------------
module cdw_queue (
  input  logic       clk,
  input  logic       rst,
  cdw_job_if.sink    push,
  cdw_job_if.source  pop
);

  localparam int PTR_W = $clog2(cdw_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(cdw_pkg::QUEUE_DEPTH + 1);

  cdw_pkg::job_t     slots [cdw_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push.ready = (count != CNT_W'(cdw_pkg::QUEUE_DEPTH));
  assign pop.valid  = (count != '0);
  assign pop.job    = slots[rd_ptr];
  assign do_push    = push.valid && push.ready;
  assign do_pop     = pop.valid && pop.ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(cdw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(cdw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      priority if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end else begin
        count <= count;
      end
    end
  end

endmodule

// ===== sv/cdw_back.sv =====
// ----------------------------------------------------------------------------
// cdw_back
// Renders the head job one glyph row a cycle, stalls aside, into a registered output.
// ----------------------------------------------------------------------------
module cdw_back #(
  parameter int GLYPH_ROWS = cdw_pkg::GLYPH_ROWS_DEF,
  parameter int GLYPH_COLS = cdw_pkg::GLYPH_COLS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  cdw_job_if.sink    jobq,
  cdw_row_if.source  pix
);

  localparam int ROW_W = $clog2(GLYPH_ROWS);
  localparam int CMP_W = (ROW_W > 4) ? ROW_W : 4;
  localparam int PIX_W = cdw_pkg::NDIG * GLYPH_COLS;
  localparam int PAD_W = (PIX_W > cdw_pkg::PIX_OUT_W) ? PIX_W : cdw_pkg::PIX_OUT_W;

  logic [ROW_W-1:0] row;
  logic             is_last;
  logic             slot_free;
  logic             emit;
  logic [PAD_W-1:0] line;
  logic             out_valid;

  assign is_last    = (row == ROW_W'(GLYPH_ROWS - 1));
  assign slot_free  = !out_valid || pix.ready;
  assign emit       = jobq.valid && slot_free;
  assign jobq.ready = emit && is_last;
  assign pix.valid  = out_valid;

  // Pick old or new digit per row, then lay out glyph columns, hours tens on top.
  always_comb begin
    cdw_pkg::digit_t dg;
    logic [5:0]      glyph;
    line = '0;
    for (int k = 0; k < cdw_pkg::NDIG; k++) begin
      dg = (CMP_W'(jobq.job.frame) > CMP_W'(row)) ? jobq.job.cur[k] : jobq.job.prev[k];
      glyph = cdw_pkg::font_row(dg, 5'(row));
      for (int c = 0; c < GLYPH_COLS; c++) begin
        if (c < cdw_pkg::FONT_COLS) begin
          line[(cdw_pkg::NDIG - 1 - k) * GLYPH_COLS + (GLYPH_COLS - 1 - c)] =
            glyph[cdw_pkg::FONT_COLS - 1 - c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pix.row_index  <= 4'(row);
      pix.row_pixels <= line[cdw_pkg::PIX_OUT_W-1:0];
      pix.colon_on   <= (CMP_W'(row) == CMP_W'(1)) || (CMP_W'(row) == CMP_W'(3));
      pix.last_row   <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        row       <= is_last ? '0 : row + 1'b1;
      end else if (pix.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/clock_digit_wipe_renderer_unit.sv =====
// ----------------------------------------------------------------------------
// clock_digit_wipe_renderer_unit
// 24-hour clock with a six-digit bitmap display that wipes changed digits in.
// ----------------------------------------------------------------------------
// Channels: cmd takes tick, render and load items; pix gives pixel rows.
// A tick advances the time by one second and a load sets it (values out of
// range saturate); neither gives a row. A render item gives GLYPH_ROWS rows,
// row 0 first, the last one flagged by last_row. In row r a digit shows the
// new time where frame > r and the time before the last tick elsewhere.
// Path: a taken render item is written into the job queue, and its rows are
// registered on pix, one a cycle while pix does not stall.
// Flow: a tick or load is taken whenever cmd is ready; a render holds the row
// sequencer of the back end until its last row is drawn, so renders are drawn
// one after another. A two-entry job queue lets the next commands be taken
// while rows are still being drawn.
// Reset: the time goes to 00:00:00 for both copies, the queue empties and no
// row is shown.
// Stall: a row held on pix stays put until taken; rendering pauses, the queue
// fills and cmd drops ready once one render is being drawn and another waits.
// ----------------------------------------------------------------------------
module clock_digit_wipe_renderer_unit #(
  parameter int GLYPH_ROWS = cdw_pkg::GLYPH_ROWS_DEF,
  parameter int GLYPH_COLS = cdw_pkg::GLYPH_COLS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  cdw_cmd_if.sink    cmd,
  cdw_row_if.source  pix
);

  // front to queue, queue to back
  cdw_job_if to_queue ();
  cdw_job_if to_back ();

  // Hold the time, snapshot it into render jobs.
  cdw_front u_front (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .jobq (to_queue)
  );

  // Buffer render jobs so intake and drawing stall on their own.
  cdw_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (to_queue),
    .pop  (to_back)
  );

  // Draw one row a cycle into the output register unless pix stalls; drop the job after its last row.
  cdw_back #(
    .GLYPH_ROWS (GLYPH_ROWS),
    .GLYPH_COLS (GLYPH_COLS)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .jobq (to_back),
    .pix  (pix)
  );

endmodule

// ===== sv/cdw_checker.sv =====
// ----------------------------------------------------------------------------
// cdw_checker
// Port-level checks on the pixel row stream of the renderer.
// ----------------------------------------------------------------------------
`include "clock_digit_wipe_renderer_unit_defines.svh"

module cdw_checker (
  input logic        clk,
  input logic        rst,
  input logic        pix_valid,
  input logic        pix_ready,
  input logic [3:0]  pix_row_index,
  input logic [35:0] pix_row_pixels,
  input logic        pix_last_row
);

  // A stalled row must not change.
  `CDW_ASSERT_NEXT(a_row_hold, clk, rst, pix_valid && !pix_ready, pix_valid && $stable(pix_row_pixels) && $stable(pix_row_index), "pixel row changed while stalled")

  // Rows of one frame come without gaps and in order.
  `CDW_ASSERT_NEXT(a_row_seq, clk, rst, pix_valid && pix_ready && !pix_last_row, pix_valid && (pix_row_index == $past(pix_row_index) + 4'd1), "row sequence broken inside a frame")

  // A new frame starts at row zero.
  `CDW_ASSERT_NEXT(a_frame_start, clk, rst, pix_valid && pix_ready && pix_last_row, !pix_valid || (pix_row_index == 4'd0), "frame did not restart at row zero")

  // Reset leaves no row on show.
  `CDW_ASSERT_ALWAYS(a_reset_idle, clk, rst, !pix_valid, "row shown after reset")

endmodule

bind clock_digit_wipe_renderer_unit cdw_checker u_cdw_checker (
  .clk            (clk),
  .rst            (rst),
  .pix_valid      (pix.valid),
  .pix_ready      (pix.ready),
  .pix_row_index  (pix.row_index),
  .pix_row_pixels (pix.row_pixels),
  .pix_last_row   (pix.last_row)
);

// ===== test/tb_clock_digit_wipe_renderer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_clock_digit_wipe_renderer_unit
// Checks the digit wipe clock against its own model of the time and the
// font. Tick, load and render items are queued up front and driven in phases
// of sender idling and receiver stalling. Every pixel row is compared
// against the rows the model expects.
// ----------------------------------------------------------------------------
module tb_clock_digit_wipe_renderer_unit;

  localparam int ROWS        = 10;
  localparam int DIGITS      = 6;
  localparam int DAY_SECONDS = 60 * 60 * 24;
  localparam int TAIL_CYCLES = 20;
  localparam int RANDOM_ITEMS = 72;

  // Mode code that the block must ignore.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Glyph rows of the digits 0 to 9; bit 5 is the leftmost column.
  localparam logic [5:0] GLYPHS [10][10] = '{
    '{6'h3F,6'h33,6'h33,6'h33,6'h33,6'h33,6'h33,6'h33,6'h3F,6'h3F},
    '{6'h0C,6'h0C,6'h0C,6'h0C,6'h0C,6'h0C,6'h0C,6'h0C,6'h0C,6'h0C},
    '{6'h3F,6'h3F,6'h03,6'h03,6'h3F,6'h3F,6'h30,6'h30,6'h3F,6'h3F},
    '{6'h3F,6'h3F,6'h03,6'h03,6'h3F,6'h3F,6'h03,6'h03,6'h3F,6'h3F},
    '{6'h33,6'h33,6'h33,6'h33,6'h3F,6'h3F,6'h03,6'h03,6'h03,6'h03},
    '{6'h3F,6'h3F,6'h30,6'h30,6'h3F,6'h3F,6'h03,6'h03,6'h3F,6'h3F},
    '{6'h3F,6'h3F,6'h30,6'h30,6'h3F,6'h3F,6'h33,6'h33,6'h3F,6'h3F},
    '{6'h3F,6'h3F,6'h03,6'h03,6'h03,6'h03,6'h03,6'h03,6'h03,6'h03},
    '{6'h3F,6'h3F,6'h33,6'h33,6'h3F,6'h3F,6'h33,6'h33,6'h3F,6'h3F},
    '{6'h3F,6'h3F,6'h33,6'h33,6'h3F,6'h3F,6'h03,6'h03,6'h03,6'h03}
  };

  // One command item plus the idling that applies while it is driven.
  typedef struct {
    logic [1:0]  mode;
    logic [3:0]  frame;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    bit          drain_first;
    int unsigned src_pct;
    int unsigned snk_pct;
  } cmd_item_t;

  typedef struct {
    logic [3:0]  idx;
    logic [35:0] pixels;
    logic        colon;
    logic        last;
  } pixel_row_t;

  logic clk;
  logic rst;

  cdw_cmd_if cmd_ch ();
  cdw_row_if pix_ch ();

  clock_digit_wipe_renderer_unit dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .pix (pix_ch)
  );

  // Model of the clock: the time now and the time before the last tick.
  logic [3:0] time_now  [DIGITS];
  logic [3:0] time_prev [DIGITS];

  cmd_item_t   pending_items [$];
  pixel_row_t  expected_rows [$];
  cmd_item_t   item_on_bus;
  int unsigned items_total;
  int unsigned items_taken;
  int unsigned errors;
  int unsigned snk_pct;

  // --------------------------------------------------------------------------
  // Clock, reset and the limit on the run
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2400000;
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Model of the clock and the display
  // --------------------------------------------------------------------------

  // Write hours, minutes and seconds into the current time as BCD pairs.
  task automatic store_time(int h, int m, int s);
    time_now[0] = 4'(h / 10);
    time_now[1] = 4'(h % 10);
    time_now[2] = 4'(m / 10);
    time_now[3] = 4'(m % 10);
    time_now[4] = 4'(s / 10);
    time_now[5] = 4'(s % 10);
  endtask

  function automatic logic [5:0] glyph_bits(logic [3:0] digit, int row);
    if (digit > 4'd9 || row >= 10) return '0;
    return GLYPHS[digit][row];
  endfunction

  // Work out the effect of one accepted item on the clock and the rows.
  task automatic apply_item(cmd_item_t it);
    int         total;
    int         h;
    int         m;
    int         s;
    pixel_row_t row;
    logic [3:0] digit;
    case (it.mode)
      cdw_pkg::MODE_TICK: begin
        // Remember the old time, then advance one second with day wrap.
        time_prev = time_now;
        total = (int'(time_now[0]) * 10 + int'(time_now[1])) * 3600
              + (int'(time_now[2]) * 10 + int'(time_now[3])) * 60
              + int'(time_now[4]) * 10 + int'(time_now[5]);
        total = (total + 1) % DAY_SECONDS;
        store_time(total / 3600, (total / 60) % 60, total % 60);
      end
      cdw_pkg::MODE_LOAD: begin
        // Saturate out-of-range values; both copies take the new time.
        h = (it.hours > 5'd23) ? 23 : int'(it.hours);
        m = (it.minutes > 6'd59) ? 59 : int'(it.minutes);
        s = (it.seconds > 6'd59) ? 59 : int'(it.seconds);
        store_time(h, m, s);
        time_prev = time_now;
      end
      cdw_pkg::MODE_RENDER: begin
        // Rows above the frame index show the new digit, the rest the old.
        for (int r = 0; r < ROWS; r++) begin
          row.pixels = '0;
          for (int k = 0; k < DIGITS; k++) begin
            digit = (int'(it.frame) > r) ? time_now[k] : time_prev[k];
            row.pixels = {row.pixels[29:0], glyph_bits(digit, r)};
          end
          row.idx   = 4'(r);
          row.colon = (r == 1 || r == 3);
          row.last  = (r == ROWS - 1);
          expected_rows.push_back(row);
        end
      end
      default: begin
        // Unused mode: no change and no rows.
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void add_item(logic [1:0] mode, logic [3:0] frame,
                                   logic [4:0] h, logic [5:0] m, logic [5:0] s,
                                   bit drain, int unsigned src, int unsigned snk);
    cmd_item_t it;
    it.mode        = mode;
    it.frame       = frame;
    it.hours       = h;
    it.minutes     = m;
    it.seconds     = s;
    it.drain_first = drain;
    it.src_pct     = src;
    it.snk_pct     = snk;
    pending_items.push_back(it);
  endfunction

  task automatic build_directed();
    // Reset time, then the frame extremes.
    add_item(cdw_pkg::MODE_RENDER, 4'd0,  5'd0,  6'd0,  6'd0,  0, 0, 0);
    add_item(cdw_pkg::MODE_RENDER, 4'd15, 5'd0,  6'd0,  6'd0,  0, 0, 0);
    // Unused mode with every set bit high must change nothing.
    add_item(MODE_UNUSED,          4'd15, 5'd31, 6'd63, 6'd63, 0, 0, 0);
    add_item(cdw_pkg::MODE_RENDER, 4'd10, 5'd0,  6'd0,  6'd0,  0, 0, 0);
    // Saturating load to 23:59:59, then the midnight wrap.
    add_item(cdw_pkg::MODE_LOAD,   4'd0,  5'd31, 6'd63, 6'd63, 0, 0, 0);
    add_item(cdw_pkg::MODE_RENDER, 4'd0,  5'd0,  6'd0,  6'd0,  0, 0, 0);
    add_item(cdw_pkg::MODE_TICK,   4'd0,  5'd0,  6'd0,  6'd0,  0, 0, 0);
    add_item(cdw_pkg::MODE_RENDER, 4'd0,  5'd0,  6'd0,  6'd0,  0, 0, 0);
    add_item(cdw_pkg::MODE_RENDER, 4'd5,  5'd0,  6'd0,  6'd0,  0, 0, 0);
    add_item(cdw_pkg::MODE_RENDER, 4'd9,  5'd0,  6'd0,  6'd0,  0, 0, 0);
    add_item(cdw_pkg::MODE_RENDER, 4'd10, 5'd0,  6'd0,  6'd0,  0, 0, 0);
    // Hours ones carry into hours tens.
    add_item(cdw_pkg::MODE_LOAD,   4'd0,  5'd9,  6'd59, 6'd59, 0, 0, 0);
    add_item(cdw_pkg::MODE_TICK,   4'd0,  5'd0,  6'd0,  6'd0,  0, 0, 0);
    add_item(cdw_pkg::MODE_RENDER, 4'd3,  5'd0,  6'd0,  6'd0,  0, 0, 0);
    add_item(cdw_pkg::MODE_LOAD,   4'd0,  5'd19, 6'd59, 6'd58, 0, 0, 0);
    add_item(cdw_pkg::MODE_TICK,   4'd0,  5'd0,  6'd0,  6'd0,  0, 0, 0);
    add_item(cdw_pkg::MODE_TICK,   4'd0,  5'd0,  6'd0,  6'd0,  0, 0, 0);
    // Hold the sender back until every row so far has come out.
    add_item(cdw_pkg::MODE_RENDER, 4'd7,  5'd0,  6'd0,  6'd0,  1, 0, 0);
    add_item(cdw_pkg::MODE_LOAD,   4'd0,  5'd0,  6'd0,  6'd9,  0, 0, 0);
    add_item(cdw_pkg::MODE_TICK,   4'd0,  5'd0,  6'd0,  6'd0,  0, 0, 0);
    add_item(cdw_pkg::MODE_RENDER, 4'd1,  5'd0,  6'd0,  6'd0,  0, 0, 0);
    add_item(cdw_pkg::MODE_LOAD,   4'd0,  5'd12, 6'd34, 6'd56, 0, 0, 0);
    add_item(cdw_pkg::MODE_RENDER, 4'd12, 5'd0,  6'd0,  6'd0,  0, 0, 0);
  endtask

  task automatic build_random();
    int unsigned src_tbl [4] = '{0, 57, 0, 17};
    int unsigned snk_tbl [4] = '{0, 0, 57, 17};
    int unsigned counted;
    int unsigned pick;
    int unsigned phase;
    bit          drain;
    logic [1:0]  mode;
    logic [3:0]  frame;
    logic [4:0]  h;
    logic [5:0]  m;
    logic [5:0]  s;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      // Eight stretches of nine items cycle through the idling phases
      // twice; drain the rows at the start of each stretch.
      phase = (counted / 9) % 4;
      drain = (counted % 9 == 0);
      pick  = $urandom_range(99);
      frame = 4'($urandom);
      h     = 5'($urandom);
      m     = 6'($urandom);
      s     = 6'($urandom);
      if (pick < 35) begin
        mode = cdw_pkg::MODE_TICK;
      end else if (pick < 65) begin
        mode = cdw_pkg::MODE_RENDER;
        // Keep most frames inside the glyph, a few beyond it.
        if ($urandom_range(3) != 0) frame = 4'($urandom_range(10));
      end else if (pick < 93) begin
        mode = cdw_pkg::MODE_LOAD;
        pick = $urandom_range(99);
        if (pick < 60) begin
          // Close to a rollover so the following ticks carry far.
          h = 5'($urandom_range(23));
          m = ($urandom_range(1) != 0) ? 6'd59 : 6'($urandom_range(59));
          s = 6'($urandom_range(59, 55));
        end else if (pick < 85) begin
          h = 5'($urandom_range(23));
          m = 6'($urandom_range(59));
          s = 6'($urandom_range(59));
        end
      end else begin
        mode = MODE_UNUSED;
      end
      add_item(mode, frame, h, m, s, drain, src_tbl[phase], snk_tbl[phase]);
      if (mode != MODE_UNUSED) counted++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: present pending items on cmd and feed accepted ones to the model
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : cmd_driver
    bit taken;
    bit launch;
    if (rst) begin
      cmd_ch.valid       <= 1'b0;
      cmd_ch.mode        <= cdw_pkg::MODE_TICK;
      cmd_ch.frame       <= '0;
      cmd_ch.set_hours   <= '0;
      cmd_ch.set_minutes <= '0;
      cmd_ch.set_seconds <= '0;
    end else begin
      taken  = cmd_ch.valid && cmd_ch.ready;
      launch = 1'b0;
      if (taken) begin
        apply_item(item_on_bus);
        items_taken++;
      end
      // Hold an item that has not been taken yet.
      if (!cmd_ch.valid || taken) begin
        if (pending_items.size() > 0) begin
          if (pending_items[0].drain_first && expected_rows.size() > 0) begin
            launch = 1'b0;
          end else begin
            launch = ($urandom_range(99) >= pending_items[0].src_pct);
          end
        end
        if (launch) begin
          item_on_bus = pending_items.pop_front();
          snk_pct     = item_on_bus.snk_pct;
          cmd_ch.mode        <= item_on_bus.mode;
          cmd_ch.frame       <= item_on_bus.frame;
          cmd_ch.set_hours   <= item_on_bus.hours;
          cmd_ch.set_minutes <= item_on_bus.minutes;
          cmd_ch.set_seconds <= item_on_bus.seconds;
        end
        cmd_ch.valid <= launch;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: stall pix at random and check each row taken
  // --------------------------------------------------------------------------
  task automatic report(string field, logic [63:0] want, logic [63:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    errors++;
  endtask

  always @(posedge clk) begin : pix_monitor
    pixel_row_t want;
    if (rst) begin
      pix_ch.ready <= 1'b0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        if (expected_rows.size() == 0) begin
          $display("%0t: unexpected row, expected none, actual index %0d pixels %0h",
                   $time, pix_ch.row_index, pix_ch.row_pixels);
          errors++;
        end else begin
          want = expected_rows.pop_front();
          if (pix_ch.row_index !== want.idx)     report("row_index", want.idx, pix_ch.row_index);
          if (pix_ch.row_pixels !== want.pixels) report("row_pixels", want.pixels,
                                                        pix_ch.row_pixels);
          if (pix_ch.colon_on !== want.colon)    report("colon_on", want.colon, pix_ch.colon_on);
          if (pix_ch.last_row !== want.last)     report("last_row", want.last, pix_ch.last_row);
        end
      end
      pix_ch.ready <= ($urandom_range(99) >= snk_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Sequence of the run
  // --------------------------------------------------------------------------
  initial begin : run_sequence
    errors      = 0;
    items_taken = 0;
    snk_pct     = 0;
    for (int k = 0; k < DIGITS; k++) begin
      time_now[k]  = '0;
      time_prev[k] = '0;
    end
    build_directed();
    build_random();
    items_total = pending_items.size();
    // Advance until every item is in, then until every row is out.
    while (items_taken < items_total) @(posedge clk);
    while (expected_rows.size() > 0) @(posedge clk);
    // Drop into a quiet tail to catch any stray row.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && expected_rows.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
